>>> src/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
`default_nettype none
package rfa_pkg;

    localparam int DEFAULT_WORD_BITS = 32;
    localparam int FIELD_BITS        = 32;
    localparam int OP_BITS           = 2;
    localparam int STATUS_BITS       = 2;
    localparam int IN_DATA_BITS      = 136;
    localparam int OUT_DATA_BITS     = 72;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Control that travels beside the magnitudes from the front's combine stage through every GCD and division stage.
    typedef struct packed {
        logic valid;
        logic zero_den;
        logic num_neg;
        logic den_neg;
    } ctl_t;

endpackage
`default_nettype wire

>>> src/rfa_front.sv
// Operand decode, cross products and signed-magnitude combine (three stages).
`default_nettype none
module rfa_front #(
    parameter int WORD_BITS = rfa_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            adv,
    input  wire logic                            in_valid,
    input  wire rfa_pkg::op_t                    in_op,
    input  wire logic [rfa_pkg::FIELD_BITS-1:0]  a_num,
    input  wire logic [rfa_pkg::FIELD_BITS-1:0]  a_den,
    input  wire logic [rfa_pkg::FIELD_BITS-1:0]  b_num,
    input  wire logic [rfa_pkg::FIELD_BITS-1:0]  b_den,
    output rfa_pkg::ctl_t                        ctl_o,
    output logic [2*WORD_BITS-1:0]               num_mag_o,
    output logic [2*WORD_BITS-1:0]               den_mag_o
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;

    // {sign, magnitude} of the low W bits read as two's complement
    function automatic logic [W:0] decode(input logic [rfa_pkg::FIELD_BITS-1:0] raw);
        logic [W-1:0] v;
        v = raw[W-1:0];
        decode = {v[W-1], (v[W-1] ? (~v + 1'b1) : v)};
    endfunction

    logic          v1_reg;
    rfa_pkg::op_t  op1_reg;
    logic [W:0]    an1_reg, ad1_reg, bn1_reg, bd1_reg;

    logic          v2_reg;
    rfa_pkg::op_t  op2_reg;
    logic [PW-1:0] p1_reg, p2_reg, pd_reg;
    logic          s1_reg, s2_reg, sd_reg;

    logic [W:0]    m1_b, md_b;
    logic [PW-1:0] p1_next, p2_next, pd_next;
    logic          s1_next, s2_next, sd_next;

    logic [PW-1:0] num_next;
    logic          num_neg_next;
    logic          addsub;

    always_comb begin
        m1_b    = (op1_reg == rfa_pkg::OP_MUL) ? bn1_reg : bd1_reg;
        md_b    = (op1_reg == rfa_pkg::OP_DIV) ? bn1_reg : bd1_reg;
        p1_next = PW'(an1_reg[W-1:0]) * PW'(m1_b[W-1:0]);
        p2_next = PW'(bn1_reg[W-1:0]) * PW'(ad1_reg[W-1:0]);
        pd_next = PW'(ad1_reg[W-1:0]) * PW'(md_b[W-1:0]);
        s1_next = an1_reg[W] ^ m1_b[W];
        s2_next = bn1_reg[W] ^ ad1_reg[W] ^ (op1_reg == rfa_pkg::OP_SUB);
        sd_next = ad1_reg[W] ^ md_b[W];
    end

    always_comb begin
        addsub       = (op2_reg == rfa_pkg::OP_ADD) || (op2_reg == rfa_pkg::OP_SUB);
        num_next     = p1_reg;
        num_neg_next = s1_reg;
        if (addsub) begin
            if (s1_reg == s2_reg) begin
                num_next = p1_reg + p2_reg;
            end else if (p1_reg >= p2_reg) begin
                num_next = p1_reg - p2_reg;
            end else begin
                num_next     = p2_reg - p1_reg;
                num_neg_next = s2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ctl_o  <= '0;
        end else if (adv) begin
            v1_reg         <= in_valid;
            op1_reg        <= in_op;
            an1_reg        <= decode(a_num);
            ad1_reg        <= decode(a_den);
            bn1_reg        <= decode(b_num);
            bd1_reg        <= decode(b_den);
            v2_reg         <= v1_reg;
            op2_reg        <= op1_reg;
            p1_reg         <= p1_next;
            p2_reg         <= p2_next;
            pd_reg         <= pd_next;
            s1_reg         <= s1_next;
            s2_reg         <= s2_next;
            sd_reg         <= sd_next;
            ctl_o.valid    <= v2_reg;
            ctl_o.zero_den <= (pd_reg == '0);
            ctl_o.num_neg  <= num_neg_next;
            ctl_o.den_neg  <= sd_reg;
            num_mag_o      <= num_next;
            den_mag_o      <= pd_reg;
        end
    end

endmodule
`default_nettype wire

>>> src/rfa_gcd.sv
// Binary GCD, one reduction step per stage, then the common power of two restored.
`default_nettype none
module rfa_gcd #(
    parameter int WORD_BITS = rfa_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire rfa_pkg::ctl_t           ctl_i,
    input  wire logic [2*WORD_BITS-1:0]  num_i,
    input  wire logic [2*WORD_BITS-1:0]  den_i,
    output rfa_pkg::ctl_t                ctl_o,
    output logic [2*WORD_BITS-1:0]       num_o,
    output logic [2*WORD_BITS-1:0]       den_o,
    output logic [2*WORD_BITS-1:0]       gcd_o
);

    localparam int PW = 2 * WORD_BITS;
    localparam int NG = 2 * PW;
    localparam int KW = $clog2(PW);

    rfa_pkg::ctl_t ctl_src [NG];
    logic [PW-1:0] u_src [NG], v_src [NG], n_src [NG], d_src [NG];
    logic [KW-1:0] k_src [NG];

    rfa_pkg::ctl_t ctl_reg [NG];
    logic [PW-1:0] u_reg [NG], v_reg [NG], n_reg [NG], d_reg [NG];
    logic [KW-1:0] k_reg [NG];

    logic [PW-1:0] u_next [NG], v_next [NG];
    logic [KW-1:0] k_next [NG];

    always_comb begin
        ctl_src[0] = ctl_i;
        u_src[0]   = num_i;
        v_src[0]   = den_i;
        n_src[0]   = num_i;
        d_src[0]   = den_i;
        k_src[0]   = '0;
        for (int j = 1; j < NG; j++) begin
            ctl_src[j] = ctl_reg[j-1];
            u_src[j]   = u_reg[j-1];
            v_src[j]   = v_reg[j-1];
            n_src[j]   = n_reg[j-1];
            d_src[j]   = d_reg[j-1];
            k_src[j]   = k_reg[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < NG; j++) begin
            u_next[j] = u_src[j];
            v_next[j] = v_src[j];
            k_next[j] = k_src[j];
            // hold once either side reaches zero
            priority if (u_src[j] == '0 || v_src[j] == '0) begin
                k_next[j] = k_src[j];
            end else if (!u_src[j][0] && !v_src[j][0]) begin
                u_next[j] = u_src[j] >> 1;
                v_next[j] = v_src[j] >> 1;
                k_next[j] = k_src[j] + 1'b1;
            end else if (!u_src[j][0]) begin
                u_next[j] = u_src[j] >> 1;
            end else if (!v_src[j][0]) begin
                v_next[j] = v_src[j] >> 1;
            end else if (u_src[j] >= v_src[j]) begin
                u_next[j] = (u_src[j] - v_src[j]) >> 1;
            end else begin
                v_next[j] = (v_src[j] - u_src[j]) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NG; j++) begin
                ctl_reg[j] <= '0;
            end
            ctl_o <= '0;
        end else if (adv) begin
            for (int j = 0; j < NG; j++) begin
                ctl_reg[j] <= ctl_src[j];
                u_reg[j]   <= u_next[j];
                v_reg[j]   <= v_next[j];
                n_reg[j]   <= n_src[j];
                d_reg[j]   <= d_src[j];
                k_reg[j]   <= k_next[j];
            end
            ctl_o <= ctl_reg[NG-1];
            num_o <= n_reg[NG-1];
            den_o <= d_reg[NG-1];
            gcd_o <= (u_reg[NG-1] | v_reg[NG-1]) << k_reg[NG-1];
        end
    end

endmodule
`default_nettype wire

>>> src/rfa_div.sv
// Restoring division of both magnitudes by the GCD, one quotient bit per stage.
`default_nettype none
module rfa_div #(
    parameter int WORD_BITS = rfa_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire rfa_pkg::ctl_t           ctl_i,
    input  wire logic [2*WORD_BITS-1:0]  num_i,
    input  wire logic [2*WORD_BITS-1:0]  den_i,
    input  wire logic [2*WORD_BITS-1:0]  gcd_i,
    output rfa_pkg::ctl_t                ctl_o,
    output logic [2*WORD_BITS-1:0]       num_q_o,
    output logic [2*WORD_BITS-1:0]       den_q_o
);

    localparam int PW = 2 * WORD_BITS;

    rfa_pkg::ctl_t ctl_src [PW];
    logic [PW-1:0] rn_src [PW], rd_src [PW], qn_src [PW], qd_src [PW], g_src [PW];

    rfa_pkg::ctl_t ctl_reg [PW];
    logic [PW-1:0] rn_reg [PW], rd_reg [PW], qn_reg [PW], qd_reg [PW], g_reg [PW];

    logic [PW-1:0] rn_next [PW], rd_next [PW], qn_next [PW], qd_next [PW];
    logic          hit_n [PW], hit_d [PW];

    always_comb begin
        ctl_src[0] = ctl_i;
        rn_src[0]  = num_i;
        rd_src[0]  = den_i;
        qn_src[0]  = '0;
        qd_src[0]  = '0;
        g_src[0]   = gcd_i;
        for (int i = 1; i < PW; i++) begin
            ctl_src[i] = ctl_reg[i-1];
            rn_src[i]  = rn_reg[i-1];
            rd_src[i]  = rd_reg[i-1];
            qn_src[i]  = qn_reg[i-1];
            qd_src[i]  = qd_reg[i-1];
            g_src[i]   = g_reg[i-1];
        end
    end

    // stage i settles quotient bit PW-1-i
    always_comb begin
        for (int i = 0; i < PW; i++) begin
            hit_n[i]   = (rn_src[i] >> (PW-1-i)) >= g_src[i];
            hit_d[i]   = (rd_src[i] >> (PW-1-i)) >= g_src[i];
            rn_next[i] = hit_n[i] ? (rn_src[i] - (g_src[i] << (PW-1-i))) : rn_src[i];
            rd_next[i] = hit_d[i] ? (rd_src[i] - (g_src[i] << (PW-1-i))) : rd_src[i];
            qn_next[i] = {qn_src[i][PW-2:0], hit_n[i]};
            qd_next[i] = {qd_src[i][PW-2:0], hit_d[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PW; i++) begin
                ctl_reg[i] <= '0;
            end
        end else if (adv) begin
            for (int i = 0; i < PW; i++) begin
                ctl_reg[i] <= ctl_src[i];
                rn_reg[i]  <= rn_next[i];
                rd_reg[i]  <= rd_next[i];
                qn_reg[i]  <= qn_next[i];
                qd_reg[i]  <= qd_next[i];
                g_reg[i]   <= g_src[i];
            end
        end
    end

    assign ctl_o   = ctl_reg[PW-1];
    assign num_q_o = qn_reg[PW-1];
    assign den_q_o = qd_reg[PW-1];

endmodule
`default_nettype wire

>>> src/rational_fraction_alu_unit.sv
// Pipeline: decode, multiply and combine in the front end, one binary GCD reduction step
//   per stage plus the GCD output register, division by the GCD one quotient bit per
//   stage, and the output register.
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset: aresetn low on a clock edge clears all stage valid bits and the output valid.
`default_nettype none
module rational_fraction_alu_unit #(
    parameter int WORD_BITS = rfa_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // operation[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98]
    input  wire logic [rfa_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // result_num[31:0], result_den[63:32], status[65:64]
    output logic [rfa_pkg::OUT_DATA_BITS-1:0]       m_tdata
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int FB = rfa_pkg::FIELD_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

    logic adv;

    rfa_pkg::ctl_t front_ctl, gcd_ctl, div_ctl;
    logic [PW-1:0] front_num, front_den;
    logic [PW-1:0] gcd_num, gcd_den, gcd_val;
    logic [PW-1:0] num_q, den_q;

    logic                  m_valid_reg;
    logic [rfa_pkg::OUT_DATA_BITS-1:0] m_data_reg;

    logic                  num_fits, den_fits;
    logic [PW-1:0]         num_tc, den_tc;
    logic signed [W-1:0]   num_w, den_w;
    logic [FB-1:0]         res_num, res_den;
    rfa_pkg::status_t      res_status;

    // advance every stage unless a result waits on a stalled output
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    rfa_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_op     (rfa_pkg::op_t'(s_tdata[1:0])),
        .a_num     (s_tdata[33:2]),
        .a_den     (s_tdata[65:34]),
        .b_num     (s_tdata[97:66]),
        .b_den     (s_tdata[129:98]),
        .ctl_o     (front_ctl),
        .num_mag_o (front_num),
        .den_mag_o (front_den)
    );

    rfa_gcd #(.WORD_BITS(WORD_BITS)) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_i   (front_ctl),
        .num_i   (front_num),
        .den_i   (front_den),
        .ctl_o   (gcd_ctl),
        .num_o   (gcd_num),
        .den_o   (gcd_den),
        .gcd_o   (gcd_val)
    );

    rfa_div #(.WORD_BITS(WORD_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_i   (gcd_ctl),
        .num_i   (gcd_num),
        .den_i   (gcd_den),
        .gcd_i   (gcd_val),
        .ctl_o   (div_ctl),
        .num_q_o (num_q),
        .den_q_o (den_q)
    );

    always_comb begin
        num_fits = (num_q == '0) || (div_ctl.num_neg ? (num_q <= HALF) : (num_q <= HALF - 1'b1));
        den_fits = (den_q == '0) || (div_ctl.den_neg ? (den_q <= HALF) : (den_q <= HALF - 1'b1));
        num_tc   = div_ctl.num_neg ? (~num_q + 1'b1) : num_q;
        den_tc   = div_ctl.den_neg ? (~den_q + 1'b1) : den_q;
        num_w    = num_tc[W-1:0];
        den_w    = den_tc[W-1:0];
        res_num  = FB'(num_w);
        res_den  = FB'(den_w);
        priority if (div_ctl.zero_den) begin
            res_status = rfa_pkg::STATUS_ZERO_DEN;
            res_num    = '0;
            res_den    = '0;
        end else if (!num_fits || !den_fits) begin
            res_status = rfa_pkg::STATUS_OVERFLOW;
            res_num    = '0;
            res_den    = '0;
        end else begin
            res_status = rfa_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_ctl.valid;
            m_data_reg  <= {6'b0, res_status, res_den, res_num};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] != rfa_pkg::STATUS_OK) |-> m_tdata[63:0] == '0)
        else $error("error result carries nonzero fraction");

    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] == rfa_pkg::STATUS_OK) |-> m_tdata[63:32] != '0)
        else $error("good result with zero denominator");

    a_zero_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] == rfa_pkg::STATUS_OK) && (m_tdata[31:0] == '0)
        |-> (m_tdata[63:32] == 32'd1) || (m_tdata[63:32] == 32'hFFFF_FFFF))
        else $error("zero numerator not reduced to unit denominator");
`endif

endmodule
`default_nettype wire
